// ===== design/ptq_pkg.sv =====
// ============================================================================
// ptq_pkg
// Shared types and constants for the priority task queue.
// ============================================================================
`default_nettype none

package ptq_pkg;

    localparam int QUEUE_DEPTH = 128;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int TAG_W       = 16;
    localparam int PRIO_W      = 16;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
    } entry_t;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic   ins;     // sorted insert of word
        logic   ext;     // pop head, shift left
        entry_t word;
    } cell_op_t;

endpackage

`default_nettype wire

// ===== design/priority_task_queue_core.sv =====
// ============================================================================
// priority_task_queue_core
// Bounded priority task queue built as a sorted chain of cells.
// ============================================================================
// The accepting edge of start registers the command and raises busy; the
//   next edge updates every cell of the chain in parallel, registers the
//   result and raises done while busy drops. A new word is not taken while
//   busy is high, so each word executes before the next one goes in.
// Results cannot be stalled; each is on the ports for one cycle with done.
// Reset (rst_n low, async): queue empty, idle, no result pending. No
//   clearing pass; slots beyond the count are never read.
`default_nettype none

module priority_task_queue_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        mode,
    input  wire logic [ptq_pkg::TAG_W-1:0]   task_tag,
    input  wire logic [ptq_pkg::PRIO_W-1:0]  task_priority,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [ptq_pkg::TAG_W-1:0]        done_tag,
    output logic [ptq_pkg::PRIO_W-1:0]       done_priority,
    output logic [7:0]                       occupancy
);
    import ptq_pkg::*;

    // Command register, loaded on accept.
    logic   cmd_mode_reg;
    entry_t cmd_word_reg;

    // Control.
    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Result registers.
    status_t           status_reg,  status_next;
    entry_t            result_reg,  result_next;
    logic [7:0]        occ_reg,     occ_next;

    logic [CNT_W+7:0]  count_wide;

    logic     full;
    logic     empty;
    cell_op_t op;

    entry_t cell_entry [QUEUE_DEPTH];
    logic   cell_disp  [QUEUE_DEPTH];
    logic   cell_occ   [QUEUE_DEPTH];

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    // Only the execute cycle touches the chain; blocked ops are dropped here.
    always_comb
    begin
        op.ins  = busy_reg && !cmd_mode_reg && !full;
        op.ext  = busy_reg &&  cmd_mode_reg && !empty;
        op.word = cmd_word_reg;
    end

    // ---------------------------------------------------------------------
    // Cell chain. Kept sorted by priority, descending, ties in arrival
    // order, so the head always holds the task an execute removes.
    // ---------------------------------------------------------------------
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_d;

        assign cell_occ[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign left_d = 1'b0;
            assign left_e = '0;
        end
        else
        begin : g_body
            assign left_d = cell_disp[i-1];
            assign left_e = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign right_e = '0;
        end
        else
        begin : g_mid
            assign right_e = cell_entry[i+1];
        end

        ptq_cell u_cell (
            .clk         (clk),
            .op          (op),
            .occ         (cell_occ[i]),
            .left_disp   (left_d),
            .left_entry  (left_e),
            .right_entry (right_e),
            .disp        (cell_disp[i]),
            .entry       (cell_entry[i])
        );
    end

    // ---------------------------------------------------------------------
    // Control and result
    // ---------------------------------------------------------------------
    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        count_next  = count_reg;
        status_next = status_reg;
        result_next = result_reg;

        if (busy_reg)
        begin
            busy_next   = 1'b0;
            done_next   = 1'b1;
            status_next = ST_OK;
            result_next = '0;
            if (!cmd_mode_reg)
            begin
                if (full)
                    status_next = ST_FULL;
                else
                    count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    result_next = cell_entry[0];
                    count_next  = count_reg - CNT_W'(1);
                end
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
        end

        // Occupancy field carries the low 8 bits of the count.
        count_wide = {8'd0, count_next};
        occ_next   = count_wide[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // Payload, no reset.
    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            cmd_mode_reg      <= mode;
            cmd_word_reg.tag  <= task_tag;
            cmd_word_reg.prio <= task_priority;
        end
        status_reg <= status_next;
        result_reg <= result_next;
        occ_reg    <= occ_next;
    end

    assign busy          = busy_reg;
    assign done          = done_reg;
    assign status        = status_reg;
    assign done_tag      = result_reg.tag;
    assign done_priority = result_reg.prio;
    assign occupancy     = occ_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("execute cycle did not produce one result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("task count above depth");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_EMPTY)) |-> (count_reg == '0 && done_tag == '0))
        else $error("empty status with tasks held");

endmodule

`default_nettype wire

// ===== design/ptq_cell.sv =====
// ============================================================================
// ptq_cell
// One slot of the sorted chain: holds one task word, shifts left on pop,
// takes the new word or its left neighbor on a sorted insert.
// ============================================================================
`default_nettype none

module ptq_cell (
    input  wire logic             clk,
    input  wire ptq_pkg::cell_op_t op,
    input  wire logic             occ,        // slot holds a task
    input  wire logic             left_disp,  // left neighbor moves right
    input  wire ptq_pkg::entry_t  left_entry,
    input  wire ptq_pkg::entry_t  right_entry,
    output logic                  disp,       // this slot moves right
    output ptq_pkg::entry_t       entry
);
    import ptq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // Strict compare: equal priorities stay ahead, so older wins.
    assign disp  = op.ins && (!occ || (op.word.prio > entry_reg.prio));
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (op.ext)
        begin
            entry_next = right_entry;
        end
        else if (disp)
        begin
            entry_next = left_disp ? left_entry : op.word;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ============================================================================
// tb
// Testbench for priority_task_queue_core. Drives insert and execute words
// through the start/busy handshake. A scoreboard keeps its own copy of the
// task list and predicts each result: oldest-first among equal priorities,
// a full status on an insert at capacity, and an empty status on an execute
// with nothing held. Each done strobe is checked field by field.
// ============================================================================
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ptq_pkg::*;

    localparam int CLK_HALF     = 6;     // 12 ns period
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_WORDS = 1600;
    localparam int QUIET_TAIL   = 300;   // last words go with no idling
    localparam int STALL_LIMIT  = 500;   // cycles with no word moving either way
    localparam int SETTLE       = 8;     // cycles watched after the last result

    // Command encoding on the mode port.
    typedef enum logic {
        OP_INSERT  = 1'b0,
        OP_EXECUTE = 1'b1
    } op_t;

    // Priority shapes for the random part.
    typedef enum int {
        MIX_WIDE,       // full 16-bit range
        MIX_TIES,       // a handful of values, many equal priorities
        MIX_EXTREME     // only zero and all-ones
    } prio_mix_t;

    typedef struct {
        status_t           status;
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
        logic [7:0]        occupancy;
    } step_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the held tasks, oldest at index 0, plus the
    // results still owed by the block.
    // ------------------------------------------------------------------------
    class task_queue_scoreboard;
        entry_t       held_tasks[$];
        step_result_t owed_results[$];
        int           errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Accepted word: update the task list and queue the expected result.
        function void note_word(op_t op, logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio);
            step_result_t r;
            entry_t       e;
            int           best;
            r.status = ST_OK;
            r.tag    = '0;
            r.prio   = '0;
            if (op == OP_INSERT) begin
                if (held_tasks.size() >= QUEUE_DEPTH) begin
                    r.status = ST_FULL;         // dropped, list unchanged
                end
                else begin
                    e.tag  = tag;
                    e.prio = prio;
                    held_tasks.push_back(e);
                end
            end
            else if (held_tasks.size() == 0) begin
                r.status = ST_EMPTY;
            end
            else begin
                // first strictly larger wins, so the oldest keeps a tie
                best = 0;
                for (int i = 1; i < held_tasks.size(); i++)
                    if (held_tasks[i].prio > held_tasks[best].prio)
                        best = i;
                r.tag  = held_tasks[best].tag;
                r.prio = held_tasks[best].prio;
                held_tasks.delete(best);
            end
            r.occupancy = 8'(held_tasks.size());
            owed_results.push_back(r);
        endfunction

        function void field_check(string what, int unsigned exp, int unsigned act);
            if (exp != act) begin
                $display("%0t mismatch %s: expected %0h actual %0h",
                         $time, what, exp, act);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] status, logic [TAG_W-1:0] tag,
                                   logic [PRIO_W-1:0] prio, logic [7:0] occupancy);
            step_result_t r;
            if (owed_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual %s %0h %0h %0h %0d",
                         $time, "status/tag/prio/occ", status, tag, prio, occupancy);
                errors++;
                return;
            end
            r = owed_results.pop_front();
            field_check("status", r.status, status);
            field_check("done_tag", r.tag, tag);
            field_check("done_priority", r.prio, prio);
            field_check("occupancy", r.occupancy, occupancy);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------------
    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              mode;
    logic [TAG_W-1:0]  task_tag;
    logic [PRIO_W-1:0] task_priority;
    logic              done;
    logic [1:0]        status;
    logic [TAG_W-1:0]  done_tag;
    logic [PRIO_W-1:0] done_priority;
    logic [7:0]        occupancy;

    priority_task_queue_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .task_tag      (task_tag),
        .task_priority (task_priority),
        .done          (done),
        .status        (status),
        .done_tag      (done_tag),
        .done_priority (done_priority),
        .occupancy     (occupancy)
    );

    task_queue_scoreboard sb = new();

    int  words_sent;
    bit  idling_on;
    int  stall_cycles;

    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, where the inputs
    // (changed at the falling edge) are stable and the outputs still hold
    // the values of the cycle that just ended.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            // results first: a word accepted on this edge cannot also finish on it
            if (done)
                sb.check_result(status, done_tag, done_priority, occupancy);
            if (start && !busy)
                sb.note_word(op_t'(mode), task_tag, task_priority);

            // watchdog: any word moving in either direction counts as progress
            if (done || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks. Inputs only change at the falling edge, one assignment
    // each per edge.
    // ------------------------------------------------------------------------

    // Present one word and hold it until the block takes it.
    task automatic send_word(op_t op, logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio);
        @(negedge clk);
        start         <= 1'b1;
        mode          <= op;
        task_tag      <= tag;
        task_priority <= prio;
        do
            @(posedge clk);
        while (busy);
        words_sent++;
    endtask

    // Hold start low; n sets the length of the gap.
    task automatic idle_burst(int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // Send with an occasional random gap in front.
    task automatic issue(op_t op, logic [TAG_W-1:0] tag, logic [PRIO_W-1:0] prio);
        if (idling_on && $urandom_range(0, 5) == 0)
            idle_burst($urandom_range(1, 11));
        send_word(op, tag, prio);
    endtask

    // Sender holds off until every owed result is back.
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [PRIO_W-1:0] pick_priority(prio_mix_t mix);
        case (mix)
            MIX_TIES:    return PRIO_W'($urandom_range(0, 3));
            MIX_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
            default:     return PRIO_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [TAG_W-1:0] pick_tag();
        return TAG_W'($urandom_range(0, 65535));
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int        seg_len;
        int        insert_pct;
        prio_mix_t mix;
        op_t       op;

        rst_n         = 1'b0;
        start         = 1'b0;
        mode          = OP_INSERT;
        task_tag      = '0;
        task_priority = '0;
        words_sent    = 0;
        idling_on     = 1'b1;
        stall_cycles  = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // --- directed ---
        issue(OP_EXECUTE, 16'h0000, 16'h0000);   // execute with nothing held
        issue(OP_INSERT,  16'h0000, 16'h0000);   // smallest tag and priority
        issue(OP_INSERT,  16'hFFFF, 16'hFFFF);   // largest tag and priority
        issue(OP_INSERT,  16'h1234, 16'hFFFF);   // tie at the top, newer loses
        issue(OP_INSERT,  16'hAAAA, 16'h0000);   // tie at zero, newer loses
        issue(OP_INSERT,  16'h5555, 16'h8000);
        issue(OP_INSERT,  16'h00FF, 16'h7FFF);
        repeat (6) issue(OP_EXECUTE, 16'hFFFF, 16'hFFFF);
        issue(OP_EXECUTE, 16'h0000, 16'h0000);   // empty again
        issue(OP_INSERT,  16'h0001, 16'h0000);   // lone zero-priority task still leaves
        issue(OP_EXECUTE, 16'h0000, 16'h0000);
        wait_drained();

        // --- fill past capacity, then drain past empty ---
        mix = MIX_TIES;
        repeat (QUEUE_DEPTH + 6) issue(OP_INSERT, pick_tag(), pick_priority(mix));
        wait_drained();
        repeat (QUEUE_DEPTH + 6) issue(OP_EXECUTE, pick_tag(), pick_priority(mix));
        wait_drained();

        // --- random segments with varying insert/execute balance ---
        while (words_sent < RANDOM_WORDS) begin
            seg_len = $urandom_range(20, 200);
            case ($urandom_range(0, 3))
                0:       insert_pct = 20;
                1:       insert_pct = 50;
                2:       insert_pct = 80;
                default: insert_pct = 95;
            endcase
            mix       = prio_mix_t'($urandom_range(0, 2));
            idling_on = ($urandom_range(0, 9) >= 3);
            repeat (seg_len) begin
                if (words_sent >= RANDOM_WORDS)
                    break;
                if (words_sent >= RANDOM_WORDS - QUIET_TAIL)
                    idling_on = 1'b0;
                op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXECUTE;
                issue(op, pick_tag(), pick_priority(mix));
            end
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end

        // --- wind down: collect the tail, then watch for strays ---
        wait_drained();
        repeat (SETTLE) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
